[hdl/multi_waveform_oscillator_core_assert.svh]
// Assertion macros used by the checker file.
`ifndef MULTI_WAVEFORM_OSCILLATOR_CORE_ASSERT_SVH
`define MULTI_WAVEFORM_OSCILLATOR_CORE_ASSERT_SVH

// Clocked assertion, disabled while reset is held.
`define MWO_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also runs during reset.
`define MWO_ASSERT_RST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/mwo_pkg.sv]
package mwo_pkg;

  // Waveform codes as written to the wave select register
  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAW      = 2'd3
  } wave_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_WAVE_SELECT = 2'd0;
  localparam logic [1:0] CFG_PHASE_STEP  = 2'd1;
  localparam logic [1:0] CFG_AMPLITUDE   = 2'd2;

  // Register reset values
  localparam logic [31:0] RESET_PHASE_STEP = 32'd42852281;
  localparam logic [15:0] RESET_AMPLITUDE  = 16'd16384;

  // Signed full scale of a waveform value and of a sample
  localparam logic signed [15:0] FULL_SCALE = 16'sd32767;
  // Amplitude value that means unity gain in Q1.15
  localparam logic [15:0]        AMP_UNITY  = 16'd32768;

endpackage

[hdl/mwo_shaper.sv]
module mwo_shaper #(
  parameter int PHASE_BITS = 32
) (
  input  mwo_pkg::wave_e          wave_sel_i,
  input  logic [PHASE_BITS-1:0]   phase_i,
  input  logic [14:0]             sine_mag_i,
  input  logic                    sine_neg_i,
  output logic signed [15:0]      wave_o
);
  import mwo_pkg::*;

  // Rounding bias of one half at the level's weight
  localparam logic [PHASE_BITS+16:0] TRI_BIAS = (PHASE_BITS+17)'(1) << (PHASE_BITS-2);
  localparam logic [PHASE_BITS+15:0] SAW_BIAS = (PHASE_BITS+16)'(1) << (PHASE_BITS-2);

  logic                    upper_half;
  logic [PHASE_BITS-1:0]   phase_dist;
  logic [PHASE_BITS+16:0]  tri_ext;
  logic [PHASE_BITS+16:0]  tri_sum;
  logic [15:0]             tri_level;
  logic [PHASE_BITS+15:0]  saw_ext;
  logic [PHASE_BITS+15:0]  saw_sum;
  logic [15:0]             saw_level;
  logic signed [15:0]      sine_val;
  logic signed [15:0]      square_val;
  logic signed [15:0]      tri_val;
  logic signed [15:0]      saw_val;

  // Distance from the start of the cycle, folded at the half period
  assign upper_half = phase_i[PHASE_BITS-1];
  assign phase_dist = upper_half ? (PHASE_BITS'(0) - phase_i) : phase_i;

  // Triangle: 65534 * distance rounded at the half-period weight, then offset
  assign tri_ext   = (PHASE_BITS+17)'(phase_dist);
  assign tri_sum   = (tri_ext << 16) - (tri_ext << 1) + TRI_BIAS;
  assign tri_level = tri_sum[PHASE_BITS+14:PHASE_BITS-1];
  assign tri_val   = $signed(tri_level - 16'(FULL_SCALE));

  // Sawtooth: 32767 * |signed phase| rounded, sign restored
  assign saw_ext   = (PHASE_BITS+16)'(phase_dist);
  assign saw_sum   = (saw_ext << 15) - saw_ext + SAW_BIAS;
  assign saw_level = saw_sum[PHASE_BITS+14:PHASE_BITS-1];
  assign saw_val   = upper_half ? -$signed(saw_level) : $signed(saw_level);

  // Sine from the quarter table, negated in the second half
  assign sine_val  = sine_neg_i ? -$signed({1'b0, sine_mag_i}) : $signed({1'b0, sine_mag_i});

  // Square: zero at the start and at the half period
  always_comb begin
    if (phase_i[PHASE_BITS-2:0] == '0) begin
      square_val = '0;
    end else begin
      square_val = upper_half ? -FULL_SCALE : FULL_SCALE;
    end
  end

  // Pick the selected waveform
  always_comb begin
    unique case (wave_sel_i)
      WAVE_SINE:     wave_o = sine_val;
      WAVE_SQUARE:   wave_o = square_val;
      WAVE_TRIANGLE: wave_o = tri_val;
      WAVE_SAW:      wave_o = saw_val;
      default:       wave_o = sine_val;
    endcase
  end

endmodule

[hdl/multi_waveform_oscillator_core.sv]
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    restart_i, start_phase_i
// out       output     out_valid_o / out_ready_i  sample_o
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One sample per cycle while the output is not stalled; an input transfer passes
// through the stage 1, stage 2 and output registers before it can be taken out.
// The rate is set by the phase accumulator add.
// Reset clears the accumulator and loads the register defaults; no clearing pass.
// A stalled output backs up one stage at a time, so bubbles are still filled.
module multi_waveform_oscillator_core #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               restart_i,
  input  logic [31:0]        start_phase_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import mwo_pkg::*;

  localparam int QTR_SIZE = 1 << SINE_TABLE_BITS;
  localparam logic [SINE_TABLE_BITS:0] QTR_ADDR = (SINE_TABLE_BITS+1)'(QTR_SIZE);

  typedef logic [14:0] sine_rom_t [0:QTR_SIZE];

  // Quarter-wave entry: Q30 Taylor series to x^17, each term truncated
  function automatic logic [14:0] sine_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    x    = (64'd1686629713 * 64'(k)) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    v = ($unsigned(sum) * 64'd32767 + 64'd536870912) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k <= QTR_SIZE; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Configuration registers and phase state
  wave_e                 wave_q;
  logic [31:0]           step_q;
  logic [15:0]           amp_q;
  logic [PHASE_BITS-1:0] acc_q;

  // Pipeline registers
  logic                  s1_valid_q;
  logic [PHASE_BITS-1:0] s1_phase_q;
  logic [14:0]           s1_rom_q;
  logic                  s1_neg_q;
  logic                  s2_valid_q;
  logic signed [15:0]    s2_wave_q;
  logic                  out_valid_q;
  logic signed [15:0]    sample_q;

  logic                  s2_ready;
  logic                  s3_ready;
  logic                  in_xfer;
  logic [PHASE_BITS-1:0] phase_cur;
  logic [SINE_TABLE_BITS+1:0] phase_top;
  logic [1:0]            quad;
  logic [SINE_TABLE_BITS:0] rom_addr;
  logic signed [15:0]    wave_val;
  logic [15:0]           amp_clamped;
  logic [15:0]           w_abs;
  logic [30:0]           prod;
  logic [31:0]           rounded;
  logic [14:0]           mag_out;
  logic signed [15:0]    sample_d;

  // Stage ready chain
  assign s3_ready    = !out_valid_q || out_ready_i;
  assign s2_ready    = !s2_valid_q || s3_ready;
  assign in_ready_o  = !s1_valid_q || s2_ready;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Phase for this sample and the quarter-table address
  assign phase_cur = restart_i ? PHASE_BITS'(start_phase_i) : acc_q;
  assign phase_top = phase_cur[PHASE_BITS-1:PHASE_BITS-SINE_TABLE_BITS-2];
  assign quad      = phase_top[SINE_TABLE_BITS+1:SINE_TABLE_BITS];
  assign rom_addr  = quad[0] ? (QTR_ADDR - {1'b0, phase_top[SINE_TABLE_BITS-1:0]})
                             : {1'b0, phase_top[SINE_TABLE_BITS-1:0]};

  // Configuration writes and accumulator advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= WAVE_SINE;
      step_q <= RESET_PHASE_STEP;
      amp_q  <= RESET_AMPLITUDE;
      acc_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_WAVE_SELECT: wave_q <= wave_e'(cfg_data_i[1:0]);
          CFG_PHASE_STEP:  step_q <= cfg_data_i;
          CFG_AMPLITUDE:   amp_q  <= cfg_data_i[15:0];
          default:         ;
        endcase
      end
      if (in_xfer) begin
        acc_q <= phase_cur + PHASE_BITS'(step_q);
      end
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // Stage 1: capture phase and read the quarter-wave table
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_phase_q <= phase_cur;
      s1_rom_q   <= SINE_ROM[rom_addr];
      s1_neg_q   <= quad[1];
    end
  end

  // Stage 2: shape the waveform
  mwo_shaper #(
    .PHASE_BITS(PHASE_BITS)
  ) u_shaper (
    .wave_sel_i (wave_q),
    .phase_i    (s1_phase_q),
    .sine_mag_i (s1_rom_q),
    .sine_neg_i (s1_neg_q),
    .wave_o     (wave_val)
  );

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_wave_q <= wave_val;
    end
  end

  // Stage 3: scale by the clamped amplitude, round half away from zero
  assign amp_clamped = (amp_q > AMP_UNITY) ? AMP_UNITY : amp_q;
  assign w_abs       = s2_wave_q[15] ? 16'(-s2_wave_q) : 16'(s2_wave_q);
  assign prod        = w_abs[14:0] * amp_clamped;
  assign rounded     = {1'b0, prod} + 32'd16384;
  assign mag_out     = (rounded[31:15] > 17'(FULL_SCALE)) ? 15'(FULL_SCALE)
                                                          : rounded[29:15];
  assign sample_d    = s2_wave_q[15] ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      sample_q <= sample_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

endmodule

[hdl/mwo_checker.sv]
`include "multi_waveform_oscillator_core_assert.svh"

module mwo_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] sample_o
);

  // Hold a stalled sample
  `MWO_ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_o), "stalled sample changed or dropped")

  // Input backs up only when the whole pipe is blocked at the output
  `MWO_ASSERT_CLK(a_in_stall, clk_i, rst_ni, in_valid_i && !in_ready_o |-> out_valid_o && !out_ready_i, "input stalled without output backpressure")

  // Samples stay symmetric around zero
  `MWO_ASSERT_CLK(a_sample_range, clk_i, rst_ni, out_valid_o |-> sample_o != 16'h8000, "sample outside full scale")

  // Drop all pending samples under reset
  `MWO_ASSERT_RST(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o, "sample valid right after reset")

endmodule

bind multi_waveform_oscillator_core mwo_checker u_mwo_checker (.*);

[dv/multi_waveform_oscillator_core_tb.sv]
module multi_waveform_oscillator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mwo_pkg::*;

  localparam int          TABLE_BITS     = 10;
  localparam int          QTR_SIZE       = 1 << TABLE_BITS;
  localparam int          LATENCY        = 3;
  localparam int          DRAIN_CYCLES   = LATENCY + 2;
  localparam int          RX_HOLD_CYCLES = 150;
  localparam int          SWEEP_ROUNDS   = 12;
  localparam int          SWEEP_TICKS    = 100;
  localparam longint      TIMEOUT_NS     = 6_000_000;
  localparam logic [1:0]  CFG_UNUSED     = 2'd3;
  localparam logic [31:0] QUARTER_TURN   = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN      = 32'h8000_0000;
  localparam logic [31:0] THREE_QUARTERS = 32'hC000_0000;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned FULL_TURN   = 64'h1_0000_0000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               restart_i;
  logic [31:0]        start_phase_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [15:0] sample_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;

  // Oscillator copy used for prediction
  int          sine_quarter [QTR_SIZE + 1];
  logic [31:0] osc_phase;
  logic [31:0] osc_step;
  logic [15:0] osc_amp;
  wave_e       osc_wave;

  logic signed [15:0] sample_expect_q [$];
  int                 err_count;
  bit                 tx_no_gap;
  bit                 rx_no_gap;
  bit                 rx_hold_req;

  multi_waveform_oscillator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .restart_i     (restart_i),
    .start_phase_i (start_phase_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sample_o      (sample_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Quarter-wave sine in Q30 by truncated Taylor series, scaled to full scale
  function automatic void build_sine_quarter();
    longint unsigned x, x2, term, v;
    longint          sum;
    for (int k = 0; k <= QTR_SIZE; k++) begin
      x    = (HALF_PI_Q30 * longint'(k)) >> TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
      if (v > 32767) v = 32767;
      sine_quarter[k] = int'(v);
    end
  endfunction

  // Waveform value in -32767..32767 for one phase
  function automatic int wave_level(logic [31:0] ph, wave_e wave);
    longint unsigned d, lvl;
    logic [1:0]      quad;
    int              idx;
    int              s;
    case (wave)
      WAVE_SQUARE: begin
        if (ph == 32'd0 || ph == HALF_TURN) return 0;
        return (ph < HALF_TURN) ? int'(FULL_SCALE) : -int'(FULL_SCALE);
      end
      WAVE_TRIANGLE: begin
        d   = (ph < HALF_TURN) ? longint'(ph) : FULL_TURN - ph;
        lvl = (64'd65534 * d + (64'd1 << 30)) >> 31;
        return int'(lvl) - int'(FULL_SCALE);
      end
      WAVE_SAW: begin
        d   = (ph < HALF_TURN) ? longint'(ph) : FULL_TURN - ph;
        lvl = (64'd32767 * d + (64'd1 << 30)) >> 31;
        return (ph < HALF_TURN) ? int'(lvl) : -int'(lvl);
      end
      default: begin
        quad = ph[31:30];
        idx  = int'(ph[29 -: TABLE_BITS]);
        if (quad[0]) idx = QTR_SIZE - idx;
        s = sine_quarter[idx];
        return quad[1] ? -s : s;
      end
    endcase
  endfunction

  // Produce one sample and advance the phase
  function automatic logic signed [15:0] next_sample(logic restart, logic [31:0] start_phase);
    int                 lvl;
    longint unsigned    mag;
    logic [15:0]        amp;
    logic signed [15:0] smp;
    if (restart) osc_phase = start_phase;
    lvl = wave_level(osc_phase, osc_wave);
    amp = (osc_amp > AMP_UNITY) ? AMP_UNITY : osc_amp;
    mag = (lvl < 0) ? longint'(-lvl) : longint'(lvl);
    mag = (mag * amp + 64'd16384) >> 15;
    if (mag > 32767) mag = 32767;
    smp = 16'(mag);
    if (lvl < 0) smp = -smp;
    osc_phase = osc_phase + osc_step;
    return smp;
  endfunction

  // Predict on input transfers, compare on output transfers
  always @(posedge clk_i) begin : sample_scoreboard
    logic signed [15:0] want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sample_expect_q.push_back(next_sample(restart_i, start_phase_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (sample_expect_q.size() == 0) begin
          err_count++;
          $display("%0t: sample transfer with none expected: expected none, actual %0d",
                   $time, sample_o);
        end else begin
          want = sample_expect_q.pop_front();
          if (sample_o !== want) begin
            err_count++;
            $display("%0t: sample mismatch: expected %0d, actual %0d", $time, want, sample_o);
          end
        end
      end
    end
  end

  // Output ready: random stalls, a long hold on request
  initial begin : rx_ready_driver
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        stall       = RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end else if (rx_no_gap) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 11);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Offer one tick after a random gap; return at its transfer edge
  task automatic send_tick(input logic restart, input logic [31:0] start_phase);
    int unsigned gap;
    gap = tx_no_gap ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    restart_i     <= restart;
    start_phase_i <= start_phase;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and wait until every expected sample has arrived
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sample_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register write; only called with the block idle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_WAVE_SELECT: osc_wave = wave_e'(data[1:0]);
      CFG_PHASE_STEP:  osc_step = data;
      CFG_AMPLITUDE:   osc_amp  = data[15:0];
      default: ;
    endcase
    // Keep cfg_valid_i low before the next write
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_phase();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return HALF_TURN;
      2:       return 32'hFFFF_FFFF;
      3:       return QUARTER_TURN + $urandom_range(0, 3) - 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return HALF_TURN;
      3:       return $urandom_range(1, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_amp();
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return 32'(AMP_UNITY);
      2:       return 32'h0000_FFFF;
      3:       return $urandom_range(0, 32768);
      default: return $urandom;
    endcase
  endfunction

  // Reset values: default wave, step and amplitude
  task automatic test_reset_values();
    send_tick(1'b0, 32'd0);
    send_tick(1'b0, $urandom);
    send_tick(1'b1, QUARTER_TURN);
    wait_for_results();
  endtask

  // Each waveform at its corner phases, full scale, frozen phase
  task automatic test_wave_corners();
    logic [31:0] corners [5];
    corners = '{32'd0, QUARTER_TURN, HALF_TURN, THREE_QUARTERS, 32'hFFFF_FFFF};
    write_reg(CFG_PHASE_STEP, 32'd0);
    write_reg(CFG_AMPLITUDE, 32'(AMP_UNITY));
    for (int w = 0; w < 4; w++) begin
      write_reg(CFG_WAVE_SELECT, 32'(w));
      foreach (corners[i]) send_tick(1'b1, corners[i]);
      wait_for_results();
    end
  endtask

  // Amplitude clamp, masking of upper data bits, ignored index
  task automatic test_amplitude_limits();
    write_reg(CFG_WAVE_SELECT, 32'(WAVE_SINE));
    write_reg(CFG_AMPLITUDE, 32'h0000_FFFF);
    send_tick(1'b1, QUARTER_TURN);
    wait_for_results();
    write_reg(CFG_AMPLITUDE, 32'hABCD_8001);
    send_tick(1'b1, THREE_QUARTERS);
    wait_for_results();
    write_reg(CFG_AMPLITUDE, 32'd0);
    send_tick(1'b1, QUARTER_TURN);
    wait_for_results();
    write_reg(CFG_AMPLITUDE, 32'd1);
    write_reg(CFG_UNUSED, $urandom);
    send_tick(1'b1, QUARTER_TURN);
    wait_for_results();
  endtask

  // Random settings, then long runs of ticks with occasional restarts
  task automatic test_random_sweeps();
    logic [31:0] wdata;
    for (int r = 0; r < SWEEP_ROUNDS; r++) begin
      wdata = {$urandom} & 32'hFFFF_FFFC;
      write_reg(CFG_WAVE_SELECT, wdata | 32'(r % 4));
      write_reg(CFG_PHASE_STEP, pick_step());
      write_reg(CFG_AMPLITUDE, pick_amp());
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, $urandom);
      tx_no_gap = (r == 5);
      rx_no_gap = (r == 5);
      for (int i = 0; i < SWEEP_TICKS; i++) begin
        send_tick($urandom_range(0, 7) == 0, pick_phase());
      end
      tx_no_gap = 1'b0;
      rx_no_gap = 1'b0;
      wait_for_results();
    end
  endtask

  // Hold the output off while ticks keep coming
  task automatic test_output_backpressure();
    write_reg(CFG_PHASE_STEP, $urandom);
    write_reg(CFG_AMPLITUDE, 32'(AMP_UNITY));
    tx_no_gap   = 1'b1;
    rx_hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_tick(i == 0, $urandom);
    tx_no_gap = 1'b0;
    wait_for_results();
  endtask

  // Pause input until drained; the phase must carry across the pause
  task automatic test_sender_pause();
    write_reg(CFG_WAVE_SELECT, 32'(WAVE_SAW));
    write_reg(CFG_PHASE_STEP, $urandom);
    send_tick(1'b1, $urandom);
    for (int i = 0; i < 30; i++) send_tick(1'b0, $urandom);
    wait_for_results();
    for (int i = 0; i < 30; i++) send_tick(1'b0, $urandom);
    wait_for_results();
  endtask

  initial begin
    err_count     = 0;
    tx_no_gap     = 1'b0;
    rx_no_gap     = 1'b0;
    rx_hold_req   = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    restart_i     = 1'b0;
    start_phase_i = 32'd0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_WAVE_SELECT;
    cfg_data_i    = 32'd0;
    osc_phase     = 32'd0;
    osc_step      = RESET_PHASE_STEP;
    osc_amp       = RESET_AMPLITUDE;
    osc_wave      = WAVE_SINE;
    build_sine_quarter();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_wave_corners();
    test_amplitude_limits();
    test_random_sweeps();
    test_output_backpressure();
    test_sender_pause();

    wait_for_results();
    repeat (LATENCY * 4) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[multi_waveform_oscillator_core] OK");
    end else begin
      $display("[multi_waveform_oscillator_core] ERROR");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #(TIMEOUT_NS);
    $display("[multi_waveform_oscillator_core] ERROR");
    $finish;
  end

endmodule
